@@ sv/pwm_dimmed_tube_frame_driver_assert.svh @@
// assertion macros used by the frame driver core
`ifndef PWM_DIMMED_TUBE_FRAME_DRIVER_ASSERT_SVH
`define PWM_DIMMED_TUBE_FRAME_DRIVER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define PDT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("pwm_dtfd assertion failed");

// next-cycle implication, disabled while reset is low
`define PDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("pwm_dtfd assertion failed");

`endif

@@ sv/pwm_dtfd_pkg.sv @@
// types, constants and cathode maps of the pwm dimmed tube frame driver
package pwm_dtfd_pkg;

  localparam int unsigned PwmPeriodDef = 32;
  localparam int unsigned CathodeBits  = 40;
  localparam int unsigned NumTubes     = 4;
  localparam int unsigned CodeW        = 4;
  localparam int unsigned CathW        = 6;
  localparam int unsigned BrightW      = 6;
  localparam int unsigned PaddrW       = 5;
  localparam int unsigned PdataW       = 32;

  localparam logic [CathW-1:0]   BlankCath   = 6'd63;
  localparam logic [BrightW-1:0] BrightReset = 6'd32;

  // register indexes, byte address is four times the index
  localparam logic [2:0] RegBrightTube0  = 3'd0;
  localparam logic [2:0] RegBrightTube1  = 3'd1;
  localparam logic [2:0] RegBrightTube2  = 3'd2;
  localparam logic [2:0] RegBrightTube3  = 3'd3;
  localparam logic [2:0] RegBrightPeriph = 3'd4;
  localparam logic [2:0] RegBrightRing   = 3'd5;

  // brightness thresholds handed from the register file to the datapath
  typedef struct packed {
    logic [NumTubes-1:0][BrightW-1:0] tube;
    logic [BrightW-1:0]               periph;
    logic [BrightW-1:0]               ring;
  } bright_cfg_t;

  // one input transaction as held in the input register
  typedef struct packed {
    logic [CodeW-1:0] code_tube0;
    logic [CodeW-1:0] code_tube1;
    logic [CodeW-1:0] code_tube2;
    logic [CodeW-1:0] code_tube3;
    logic             colon_on;
    logic             pm_on;
    logic             alarm_on;
  } in_item_t;

  // one result transaction as held in the result register
  typedef struct packed {
    logic                   frame_valid;
    logic [CathodeBits-1:0] cathode_bits;
    logic                   colon_drive;
    logic                   pm_drive;
    logic                   alarm_drive;
  } result_t;

  // cathode index selected by a digit code on a given tube
  function automatic logic [CathW-1:0] cathode_of(input logic [1:0] tube,
                                                  input logic [CodeW-1:0] code);
    logic [CathW-1:0] c;
    c = BlankCath;
    if (code < 4'd10) begin
      unique case (tube)
        2'd0: begin
          unique case (code)
            4'd0:    c = 6'd30;
            4'd9:    c = 6'd31;
            default: c = 6'd31 + {2'b00, code};
          endcase
        end
        2'd1: c = (code == 4'd0) ? 6'd20 : 6'd30 - {2'b00, code};
        2'd2: c = (code == 4'd0) ? 6'd10 : 6'd20 - {2'b00, code};
        default: begin
          unique case (code)
            4'd0:    c = 6'd6;
            4'd1:    c = 6'd9;
            4'd2:    c = 6'd8;
            4'd3:    c = 6'd7;
            4'd4:    c = 6'd1;
            4'd5:    c = 6'd0;
            4'd6:    c = 6'd2;
            4'd7:    c = 6'd3;
            4'd8:    c = 6'd4;
            default: c = 6'd5;
          endcase
        end
      endcase
    end
    return c;
  endfunction

endpackage

@@ sv/pwm_dtfd_if.sv @@
// valid/ready channel interfaces for tick input and frame result
interface pwm_dtfd_in_if import pwm_dtfd_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] code_tube0;
  logic [CodeW-1:0] code_tube1;
  logic [CodeW-1:0] code_tube2;
  logic [CodeW-1:0] code_tube3;
  logic             colon_on;
  logic             pm_on;
  logic             alarm_on;

  modport source (output valid, code_tube0, code_tube1, code_tube2, code_tube3,
                  colon_on, pm_on, alarm_on, input ready);
  modport sink (input valid, code_tube0, code_tube1, code_tube2, code_tube3,
                colon_on, pm_on, alarm_on, output ready);
endinterface

interface pwm_dtfd_out_if import pwm_dtfd_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic                   frame_valid;
  logic [CathodeBits-1:0] cathode_bits;
  logic                   colon_drive;
  logic                   pm_drive;
  logic                   alarm_drive;

  modport source (output valid, frame_valid, cathode_bits, colon_drive, pm_drive,
                  alarm_drive, input ready);
  modport sink (input valid, frame_valid, cathode_bits, colon_drive, pm_drive,
                alarm_drive, output ready);
endinterface

@@ sv/pwm_dtfd_cfg.sv @@
// apb register file holding the six brightness thresholds
module pwm_dtfd_cfg import pwm_dtfd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output bright_cfg_t       cfg_o
);

  bright_cfg_t      cfg_q, cfg_d;
  logic             wr_en;
  logic [2:0]       reg_idx;
  logic [BrightW-1:0] wdata;
  logic [BrightW-1:0] rdata;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign wdata   = pwdata[BrightW-1:0];

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegBrightTube0:  cfg_d.tube[0] = wdata;
        RegBrightTube1:  cfg_d.tube[1] = wdata;
        RegBrightTube2:  cfg_d.tube[2] = wdata;
        RegBrightTube3:  cfg_d.tube[3] = wdata;
        RegBrightPeriph: cfg_d.periph  = wdata;
        RegBrightRing:   cfg_d.ring    = wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tube   <= {NumTubes{BrightReset}};
      cfg_q.periph <= BrightReset;
      cfg_q.ring   <= BrightReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // register read mux
  always_comb begin
    unique case (reg_idx)
      RegBrightTube0:  rdata = cfg_q.tube[0];
      RegBrightTube1:  rdata = cfg_q.tube[1];
      RegBrightTube2:  rdata = cfg_q.tube[2];
      RegBrightTube3:  rdata = cfg_q.tube[3];
      RegBrightPeriph: rdata = cfg_q.periph;
      RegBrightRing:   rdata = cfg_q.ring;
      default:         rdata = '0;
    endcase
  end

  assign prdata = {{(PdataW-BrightW){1'b0}}, rdata};
  assign cfg_o  = cfg_q;

endmodule

@@ sv/pwm_dtfd_core.sv @@
// tick datapath: input register, pwm compare and cathode map, result register
module pwm_dtfd_core import pwm_dtfd_pkg::*; #(
  parameter int unsigned PWM_PERIOD = PwmPeriodDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  bright_cfg_t cfg_i,
  pwm_dtfd_in_if.sink    in_i,
  pwm_dtfd_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(PWM_PERIOD + 1);
  localparam int unsigned CmpW = (CntW > BrightW) ? CntW : BrightW;

  `include "pwm_dimmed_tube_frame_driver_assert.svh"

  logic     s1_valid_q;
  in_item_t s1_q;
  logic     out_valid_q;
  result_t  res_q, res_d;
  logic     adv;

  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [CmpW-1:0] cnt_cmp;
  logic [NumTubes-1:0][CathW-1:0] cath_q, cath_d;
  logic [NumTubes-1:0][CodeW-1:0] codes;
  logic [NumTubes-1:0]            tube_off;
  logic periph_off, ring_off;

  // handshake: stage 1 moves on whenever the result register is free or drained
  assign adv        = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_q.code_tube0 <= in_i.code_tube0;
      s1_q.code_tube1 <= in_i.code_tube1;
      s1_q.code_tube2 <= in_i.code_tube2;
      s1_q.code_tube3 <= in_i.code_tube3;
      s1_q.colon_on   <= in_i.colon_on;
      s1_q.pm_on      <= in_i.pm_on;
      s1_q.alarm_on   <= in_i.alarm_on;
    end
  end

  // counter step and threshold compares
  assign cnt_inc    = cnt_q + 1'b1;
  assign cnt_cmp    = CmpW'(cnt_inc);
  assign cnt_d      = (cnt_cmp >= CmpW'(PWM_PERIOD)) ? '0 : cnt_inc;
  assign periph_off = cnt_cmp >= CmpW'(cfg_i.periph);
  assign ring_off   = cnt_cmp >= CmpW'(cfg_i.ring);

  assign codes[0] = s1_q.code_tube0;
  assign codes[1] = s1_q.code_tube1;
  assign codes[2] = s1_q.code_tube2;
  assign codes[3] = s1_q.code_tube3;

  // per-tube cathode select, change detect and frame build
  always_comb begin
    res_d.frame_valid  = 1'b0;
    res_d.cathode_bits = '0;
    for (int i = 0; i < NumTubes; i++) begin
      tube_off[i] = cnt_cmp >= CmpW'(cfg_i.tube[i]);
      cath_d[i]   = tube_off[i] ? BlankCath : cathode_of(2'(i), codes[i]);
      if (tube_off[i] || (cath_d[i] != cath_q[i])) begin
        res_d.frame_valid = 1'b1;
      end
      // blank cathode shifts past the top and sets nothing
      res_d.cathode_bits = res_d.cathode_bits | (CathodeBits'(1) << cath_d[i]);
    end
    res_d.colon_drive = !periph_off && s1_q.colon_on;
    res_d.pm_drive    = !periph_off && s1_q.pm_on;
    res_d.alarm_drive = !ring_off && s1_q.alarm_on;
  end

  // tick state, updated once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      cath_q <= {NumTubes{BlankCath}};
    end else if (adv) begin
      cnt_q  <= cnt_d;
      cath_q <= cath_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.frame_valid  = res_q.frame_valid;
  assign out_o.cathode_bits = res_q.cathode_bits;
  assign out_o.colon_drive  = res_q.colon_drive;
  assign out_o.pm_drive     = res_q.pm_drive;
  assign out_o.alarm_drive  = res_q.alarm_drive;

  // counter stays inside one period
  `PDT_ASSERT_IMPL(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q < CntW'(PWM_PERIOD))
  // a stalled stage 1 leaves the tick state untouched
  `PDT_ASSERT_NEXT(a_state_hold, clk_i, rst_ni, s1_valid_q && out_valid_q && !out_o.ready,
                   $stable(cnt_q) && $stable(cath_q))
  // at most one cathode per tube in a frame
  `PDT_ASSERT_IMPL(a_frame_bits, clk_i, rst_ni, out_valid_q,
                   $countones(res_q.cathode_bits) <= NumTubes)

endmodule

@@ sv/pwm_dimmed_tube_frame_driver.sv @@
// Top level of the pwm dimmed four-tube cathode frame driver.
// Path: an accepted tick transaction passes through the input register, then the
// result register, before it shows up as a result.
// Throughput: one tick per cycle while the result channel is ready; the input register refills as the result drains.
// Reset (rst_ni low, asynchronous): counter zero, all tubes blank, thresholds 32,
// both channels empty.
module pwm_dimmed_tube_frame_driver import pwm_dtfd_pkg::*; #(
  parameter int unsigned PWM_PERIOD = PwmPeriodDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pwm_dtfd_in_if.sink       in_i,
  pwm_dtfd_out_if.source    out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  bright_cfg_t cfg;

  // brightness register file
  pwm_dtfd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // tick datapath
  pwm_dtfd_core #(
    .PWM_PERIOD (PWM_PERIOD)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule
